// File: hdl/wstq_pkg.sv
// ----------------------------------------------------------------------------
// wstq_pkg
// Shared types, sizes and helpers for the work-stealing task queue block.
// ----------------------------------------------------------------------------
package wstq_pkg;

  localparam int WORKERS     = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 16;

  localparam int Q_BITS      = $clog2(WORKERS);
  localparam int SLOT_BITS   = $clog2(QUEUE_DEPTH);
  localparam int FILL_BITS   = SLOT_BITS + 1;
  localparam int ADDR_BITS   = Q_BITS + SLOT_BITS;
  localparam int STORE_DEPTH = WORKERS * QUEUE_DEPTH;
  localparam int ACT_BITS    = 3;
  localparam int CMD_BITS    = 2;
  localparam int STATUS_BITS = 2;
  localparam int PEND_BITS   = 7;
  localparam int CNT_BITS    = 32;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ENQ        = 2'd0,
    CMD_FETCH      = 2'd1,
    CMD_ASSIST_ANY = 2'd2,
    CMD_ASSIST_Q   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

  // Events raised by the sequencer towards the statistics counters
  typedef struct packed {
    logic push;
    logic take;
    logic steal;
  } stat_evt_t;

  typedef struct packed {
    logic [PEND_BITS-1:0] pending;
    logic [CNT_BITS-1:0]  spawned;
    logic [CNT_BITS-1:0]  executed;
    logic [CNT_BITS-1:0]  steals;
  } stat_cnt_t;

  // Clamp the configured count to 1..WORKERS
  function automatic logic [ACT_BITS-1:0] eff_active(input logic [ACT_BITS-1:0] a);
    logic [ACT_BITS-1:0] r;
    r = a;
    if (a == '0) begin
      r = ACT_BITS'(1);
    end else if (a > ACT_BITS'(WORKERS)) begin
      r = ACT_BITS'(WORKERS);
    end
    return r;
  endfunction

  // Reduce a queue number modulo the active count (active count is 1..4)
  function automatic logic [Q_BITS-1:0] mod_active(input logic [Q_BITS-1:0] v,
                                                   input logic [ACT_BITS-1:0] a);
    logic [Q_BITS-1:0] r;
    r = v;
    case (a)
      3'd1:    r = '0;
      3'd2:    r = {{(Q_BITS-1){1'b0}}, v[0]};
      3'd3:    r = (v == Q_BITS'(3)) ? '0 : v;
      default: r = v;
    endcase
    return r;
  endfunction

  // Next queue in ring order among the active ones
  function automatic logic [Q_BITS-1:0] ring_next(input logic [Q_BITS-1:0] v,
                                                  input logic [ACT_BITS-1:0] a);
    logic [ACT_BITS-1:0] s;
    s = ACT_BITS'(v) + ACT_BITS'(1);
    return (s >= a) ? '0 : s[Q_BITS-1:0];
  endfunction

endpackage

// File: hdl/wstq_req_if.sv
// ----------------------------------------------------------------------------
// wstq_req_if
// Request channel carrying one queue command with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wstq_req_if;
  import wstq_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_BITS-1:0] cmd;
  logic [Q_BITS-1:0]   target_queue;
  logic [TAG_BITS-1:0] task_tag;

  modport source (output valid, output cmd, output target_queue, output task_tag,
                  input ready);
  modport sink   (input valid, input cmd, input target_queue, input task_tag,
                  output ready);
endinterface

// File: hdl/wstq_rsp_if.sv
// ----------------------------------------------------------------------------
// wstq_rsp_if
// Response channel carrying one command outcome and the running counters.
// ----------------------------------------------------------------------------
interface wstq_rsp_if;
  import wstq_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [TAG_BITS-1:0]    task_out;
  logic [Q_BITS-1:0]      queue_index;
  logic                   stolen;
  logic [PEND_BITS-1:0]   pending_count;
  logic [CNT_BITS-1:0]    spawned_count;
  logic [CNT_BITS-1:0]    executed_count;
  logic [CNT_BITS-1:0]    steal_count;

  modport source (output valid, output status, output task_out, output queue_index,
                  output stolen, output pending_count, output spawned_count,
                  output executed_count, output steal_count, input ready);
  modport sink   (input valid, input status, input task_out, input queue_index,
                  input stolen, input pending_count, input spawned_count,
                  input executed_count, input steal_count, output ready);
endinterface

// File: hdl/wstq_stats.sv
// ----------------------------------------------------------------------------
// wstq_stats
// Running counters: tasks pending, spawned, executed and stolen.
// ----------------------------------------------------------------------------
module wstq_stats (
  input  logic                clk,
  input  logic                rst_n,
  input  wstq_pkg::stat_evt_t evt,
  output wstq_pkg::stat_cnt_t cnt
);
  import wstq_pkg::*;

  logic [PEND_BITS-1:0] pending_r, pending_nxt;
  logic [CNT_BITS-1:0]  spawned_r, spawned_nxt;
  logic [CNT_BITS-1:0]  executed_r, executed_nxt;
  logic [CNT_BITS-1:0]  steals_r, steals_nxt;

  // Advance on each push or take
  always_comb begin
    pending_nxt  = pending_r;
    spawned_nxt  = spawned_r;
    executed_nxt = executed_r;
    steals_nxt   = steals_r;
    if (evt.push) begin
      pending_nxt = pending_r + PEND_BITS'(1);
      spawned_nxt = spawned_r + CNT_BITS'(1);
    end else if (evt.take) begin
      pending_nxt  = pending_r - PEND_BITS'(1);
      executed_nxt = executed_r + CNT_BITS'(1);
      if (evt.steal) begin
        steals_nxt = steals_r + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      spawned_r  <= '0;
      executed_r <= '0;
      steals_r   <= '0;
    end else begin
      pending_r  <= pending_nxt;
      spawned_r  <= spawned_nxt;
      executed_r <= executed_nxt;
      steals_r   <= steals_nxt;
    end
  end

  assign cnt.pending  = pending_r;
  assign cnt.spawned  = spawned_r;
  assign cnt.executed = executed_r;
  assign cnt.steals   = steals_r;

`ifndef SYNTH
  a_steal_is_take: assert property (@(posedge clk) disable iff (!rst_n)
    evt.steal |-> evt.take) else $error("steal flagged without a take");
  a_push_xor_take: assert property (@(posedge clk) disable iff (!rst_n)
    !(evt.push && evt.take)) else $error("push and take in one cycle");
  a_pending_move: assert property (@(posedge clk) disable iff (!rst_n)
    evt.push |=> pending_r == $past(pending_r) + PEND_BITS'(1))
    else $error("pending count did not advance on push");
`endif

endmodule

// File: hdl/work_stealing_task_queues_unit.sv
// ----------------------------------------------------------------------------
// work_stealing_task_queues_unit
// Per-worker task deques with round-robin enqueue, own-back fetch, stealing
// from victims' fronts, and assist commands; one response per request.
// ----------------------------------------------------------------------------
// A response is offered once the scan has visited the queues for its request
// (one queue for an enqueue or an assist from a given queue, up to the active
// worker count for a fetch that steals or an assist from any queue) and the
// response register has been loaded. The input is ready again in the cycle
// after the load, so a new request is not accepted before the last one's
// response is loaded. The scan visits one queue per cycle through a single
// fill compare and a single port on the shared task store. The next request
// is taken once the response is loaded, even while it still waits on out_ch;
// a response left waiting holds the following request in its load cycle
// until out_ch takes the first one.
// active_workers (cfg_wdata) resets to 4; 0 acts as 1 and values above 4 as 4.
module work_stealing_task_queues_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  wstq_req_if.sink                      in_ch,
  wstq_rsp_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [wstq_pkg::ACT_BITS-1:0] cfg_wdata
);
  import wstq_pkg::*;

  state_t state_r, state_nxt;

  logic [ACT_BITS-1:0]  act_cfg_r;
  logic [ACT_BITS-1:0]  act_w;

  // Request held during the scan
  cmd_t                 cmd_r;
  logic [TAG_BITS-1:0]  tag_r;
  logic [Q_BITS-1:0]    scan_q_r;
  logic [ACT_BITS-1:0]  left_r;
  logic                 steal_mode_r;
  logic [Q_BITS-1:0]    rr_r;

  // Per-queue ring state
  logic [SLOT_BITS-1:0] head_r [WORKERS];
  logic [FILL_BITS-1:0] fill_r [WORKERS];

  // Outcome waiting for the response register
  status_t              res_status_r;
  logic [Q_BITS-1:0]    res_qidx_r;
  logic                 res_stolen_r;
  logic                 res_take_r;

  // Response register
  logic                   out_valid_r;
  logic [STATUS_BITS-1:0] out_status_r;
  logic [TAG_BITS-1:0]    out_task_r;
  logic [Q_BITS-1:0]      out_qidx_r;
  logic                   out_stolen_r;
  stat_cnt_t              out_cnt_r;

  // Task store
  logic [TAG_BITS-1:0]  store_mem [STORE_DEPTH];
  logic [TAG_BITS-1:0]  rdata_r;
  logic                 mem_we;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_addr;

  logic                 in_acc;
  logic                 resp_load;
  logic [FILL_BITS-1:0] cur_fill;
  logic [SLOT_BITS-1:0] cur_head;
  logic                 hit;
  logic                 full;
  logic                 take;
  logic                 take_front;
  logic                 scan_end;
  logic [SLOT_BITS-1:0] slot;
  stat_evt_t            evt;
  stat_cnt_t            cnt;

  assign act_w     = eff_active(act_cfg_r);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_ch.ready);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_cfg_r <= ACT_BITS'(WORKERS);
    end else if (cfg_we) begin
      act_cfg_r <= cfg_wdata;
    end
  end

  // Shared compare on the queue under visit
  always_comb begin
    cur_fill   = fill_r[scan_q_r];
    cur_head   = head_r[scan_q_r];
    hit        = (cur_fill != '0);
    full       = (cur_fill == FILL_BITS'(QUEUE_DEPTH));
    take       = (state_r == S_SCAN) && (cmd_r != CMD_ENQ) && hit;
    take_front = take && steal_mode_r;
    scan_end   = (cmd_r == CMD_ENQ) || hit || (left_r == ACT_BITS'(1));
    if (cmd_r == CMD_ENQ) begin
      slot = cur_head + cur_fill[SLOT_BITS-1:0];
    end else if (steal_mode_r) begin
      slot = cur_head;
    end else begin
      slot = cur_head + cur_fill[SLOT_BITS-1:0] - SLOT_BITS'(1);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_end) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (resp_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    evt         = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
      end
      S_SCAN: begin
        mem_we    = (cmd_r == CMD_ENQ) && !full;
        mem_re    = take;
        evt.push  = (cmd_r == CMD_ENQ) && !full;
        evt.take  = take;
        evt.steal = take_front;
      end
      default: begin
      end
    endcase
  end

  assign mem_addr = {scan_q_r, slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the request and walk the queues
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rr_r     <= '0;
      scan_q_r <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      if (in_acc) begin
        cmd_r        <= cmd_t'(in_ch.cmd);
        tag_r        <= in_ch.task_tag;
        steal_mode_r <= 1'b0;
        unique case (cmd_t'(in_ch.cmd))
          CMD_ENQ: begin
            scan_q_r <= mod_active(rr_r, act_w);
            left_r   <= ACT_BITS'(1);
          end
          CMD_FETCH: begin
            scan_q_r <= mod_active(in_ch.target_queue, act_w);
            left_r   <= act_w;
          end
          CMD_ASSIST_ANY: begin
            scan_q_r <= '0;
            left_r   <= act_w;
          end
          default: begin
            scan_q_r <= mod_active(in_ch.target_queue, act_w);
            left_r   <= ACT_BITS'(1);
          end
        endcase
      end else if (state_r == S_SCAN) begin
        if (cmd_r == CMD_ENQ) begin
          // Push to the back, or reject when full; round robin moves on
          rr_r         <= ring_next(scan_q_r, act_w);
          res_qidx_r   <= scan_q_r;
          res_stolen_r <= 1'b0;
          res_take_r   <= 1'b0;
          if (full) begin
            res_status_r <= ST_FULL;
          end else begin
            res_status_r     <= ST_OK;
            fill_r[scan_q_r] <= cur_fill + FILL_BITS'(1);
          end
        end else if (hit) begin
          // Take from the back, or from the front when stealing
          res_status_r     <= ST_OK;
          res_qidx_r       <= scan_q_r;
          res_stolen_r     <= steal_mode_r;
          res_take_r       <= 1'b1;
          fill_r[scan_q_r] <= cur_fill - FILL_BITS'(1);
          if (steal_mode_r) begin
            head_r[scan_q_r] <= cur_head + SLOT_BITS'(1);
          end
        end else if (left_r == ACT_BITS'(1)) begin
          res_status_r <= ST_EMPTY;
          res_qidx_r   <= '0;
          res_stolen_r <= 1'b0;
          res_take_r   <= 1'b0;
        end else begin
          // Miss: advance to the next queue in ring order
          scan_q_r <= ring_next(scan_q_r, act_w);
          left_r   <= left_r - ACT_BITS'(1);
          if (cmd_r == CMD_FETCH) begin
            steal_mode_r <= 1'b1;
          end
        end
      end
    end
  end

  // Task store: one write or one read per cycle, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_addr] <= tag_r;
    end
    if (mem_re) begin
      rdata_r <= store_mem[mem_addr];
    end
  end

  wstq_stats u_stats (
    .clk   (clk),
    .rst_n (rst_n),
    .evt   (evt),
    .cnt   (cnt)
  );

  // Response register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_load) begin
      out_status_r <= res_status_r;
      out_task_r   <= res_take_r ? rdata_r : '0;
      out_qidx_r   <= res_qidx_r;
      out_stolen_r <= res_stolen_r;
      out_cnt_r    <= cnt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.task_out       = out_task_r;
  assign out_ch.queue_index    = out_qidx_r;
  assign out_ch.stolen         = out_stolen_r;
  assign out_ch.pending_count  = out_cnt_r.pending;
  assign out_ch.spawned_count  = out_cnt_r.spawned;
  assign out_ch.executed_count = out_cnt_r.executed;
  assign out_ch.steal_count    = out_cnt_r.steals;

  // Total of all queue fills, checked against the pending counter
  logic [PEND_BITS-1:0] fill_sum;
  always_comb begin
    fill_sum = '0;
    for (int i = 0; i < WORKERS; i++) begin
      fill_sum = fill_sum + PEND_BITS'(fill_r[i]);
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[scan_q_r] <= FILL_BITS'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_pending_sum: assert property (@(posedge clk) disable iff (!rst_n)
    cnt.pending == fill_sum) else $error("pending count disagrees with fills");
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_SCAN) else $error("accepted request not scanned");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (left_r != '0) && (left_r <= act_w))
    else $error("scan ran past the active queues");
`endif

endmodule
